>>> rtl/core/kdq_pkg.sv
// Shared definitions for the keyed deque: field widths, request and status
// codes, and the command/status structs between controller and datapath.
// No dependencies.
package kdq_pkg;

   localparam int DEPTH_DEF        = 16;
   localparam int HANDLE_WIDTH_DEF = 32;
   localparam int TYPE_W           = 3;
   localparam int ID_W             = 32;
   localparam int HDL_PORT_W       = 32;
   localparam int STATUS_W         = 2;
   localparam int OCC_W            = 5;

   // request codes
   localparam logic [TYPE_W-1:0] OP_APPEND    = 3'd0;
   localparam logic [TYPE_W-1:0] OP_PUSH      = 3'd1;
   localparam logic [TYPE_W-1:0] OP_POP_FRONT = 3'd2;
   localparam logic [TYPE_W-1:0] OP_POP_ID    = 3'd3;
   localparam logic [TYPE_W-1:0] OP_REMOVE    = 3'd4;
   localparam logic [TYPE_W-1:0] OP_FIND      = 3'd5;
   localparam logic [TYPE_W-1:0] OP_CLEAR     = 3'd6;
   localparam logic [TYPE_W-1:0] OP_ABORT     = 3'd7;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_ABORTED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NONE    = 2'd3;

   // scan index update
   localparam logic [2:0] IDX_HOLD = 3'd0;
   localparam logic [2:0] IDX_ZERO = 3'd1;
   localparam logic [2:0] IDX_INC  = 3'd2;
   localparam logic [2:0] IDX_DEC  = 3'd3;
   localparam logic [2:0] IDX_TOP  = 3'd4;

   // store write select
   localparam logic [2:0] WR_NONE  = 3'd0;
   localparam logic [2:0] WR_BACK  = 3'd1;
   localparam logic [2:0] WR_FRONT = 3'd2;
   localparam logic [2:0] WR_UP    = 3'd3;
   localparam logic [2:0] WR_DOWN  = 3'd4;

   // entry count update
   localparam logic [1:0] CNT_HOLD = 2'd0;
   localparam logic [1:0] CNT_INC  = 2'd1;
   localparam logic [1:0] CNT_DEC  = 2'd2;
   localparam logic [1:0] CNT_CLR  = 2'd3;

   typedef struct packed {
      logic                latch;
      logic [2:0]          idx_mode;
      logic [2:0]          wr_mode;
      logic [1:0]          cnt_mode;
      logic                set_abort;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                take_hit;
      logic                out_load;
   } kdq_cmd_type;

   typedef struct packed {
      logic [TYPE_W-1:0] op;
      logic              aborted;
      logic              full;
      logic              empty;
      logic              hit;
      logic              last;
      logic              idx_zero;
      logic              out_free;
   } kdq_stat_type;

endpackage

>>> rtl/core/kdq_if.sv
// Valid/ready channel interfaces for the keyed deque: request and response.
// Depends on kdq_pkg for field widths.
interface kdq_req_if import kdq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [TYPE_W-1:0]        req_type;
   logic signed [ID_W-1:0]   key_id;
   logic [HDL_PORT_W-1:0]    entry_handle;

   modport source (output valid, output req_type, output key_id, output entry_handle,
                   input ready);
   modport sink   (input valid, input req_type, input key_id, input entry_handle,
                   output ready);
endinterface

interface kdq_rsp_if import kdq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [HDL_PORT_W-1:0] entry_out;
   logic [OCC_W-1:0]      occupancy;
   logic                  is_aborted;

   modport source (output valid, output status, output entry_out, output occupancy,
                   output is_aborted, input ready);
   modport sink   (input valid, input status, input entry_out, input occupancy,
                   input is_aborted, output ready);
endinterface

>>> rtl/core/kdq_ctrl.sv
// Controller of the keyed deque: sequences dispatch, scan and shift steps.
// Depends on kdq_pkg; drives kdq_datapath through kdq_cmd_type.
module kdq_ctrl import kdq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  kdq_stat_type st,
   output kdq_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DISP  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SHDN  = 3'd3;
   localparam logic [2:0] S_SHUP  = 3'd4;
   localparam logic [2:0] S_FRONT = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      cmd.status = ST_OK;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            // hold off transfers while reset is applied
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.latch = 1'b1;
               state_in  = S_DISP;
            end
         end
         S_DISP: begin
            unique case (st.op)
               OP_APPEND, OP_PUSH: begin
                  priority if (st.aborted) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_ABORTED;
                     state_in       = S_DONE;
                  end else if (st.full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = ST_FULL;
                     state_in       = S_DONE;
                  end else if (st.op == OP_APPEND || st.empty) begin
                     cmd.wr_mode    = (st.op == OP_APPEND) ? WR_BACK : WR_FRONT;
                     cmd.cnt_mode   = CNT_INC;
                     cmd.set_status = 1'b1;
                     state_in       = S_DONE;
                  end else begin
                     // open a slot at the front, moving the last entry first
                     cmd.idx_mode = IDX_TOP;
                     state_in     = S_SHUP;
                  end
               end
               OP_POP_FRONT, OP_POP_ID, OP_REMOVE, OP_FIND: begin
                  if (st.empty) begin
                     state_in = S_DONE;
                  end else begin
                     cmd.idx_mode = IDX_ZERO;
                     state_in     = S_SCAN;
                  end
               end
               OP_CLEAR: begin
                  cmd.cnt_mode   = CNT_CLR;
                  cmd.set_status = 1'b1;
                  state_in       = S_DONE;
               end
               OP_ABORT: begin
                  cmd.set_abort  = 1'b1;
                  cmd.cnt_mode   = CNT_CLR;
                  cmd.set_status = 1'b1;
                  state_in       = S_DONE;
               end
            endcase
         end
         S_SCAN: begin
            if (st.hit) begin
               cmd.take_hit   = 1'b1;
               cmd.set_status = 1'b1;
               priority if (st.op == OP_FIND) begin
                  state_in = S_DONE;
               end else if (st.last) begin
                  cmd.cnt_mode = CNT_DEC;
                  state_in     = S_DONE;
               end else begin
                  cmd.idx_mode = IDX_INC;
                  state_in     = S_SHDN;
               end
            end else if (st.last) begin
               state_in = S_DONE;
            end else begin
               cmd.idx_mode = IDX_INC;
            end
         end
         S_SHDN: begin
            // close the gap: move the entry just read one place forward
            cmd.wr_mode = WR_DOWN;
            if (st.last) begin
               cmd.cnt_mode = CNT_DEC;
               state_in     = S_DONE;
            end else begin
               cmd.idx_mode = IDX_INC;
            end
         end
         S_SHUP: begin
            cmd.wr_mode = WR_UP;
            if (st.idx_zero) begin
               state_in = S_FRONT;
            end else begin
               cmd.idx_mode = IDX_DEC;
            end
         end
         S_FRONT: begin
            cmd.wr_mode    = WR_FRONT;
            cmd.cnt_mode   = CNT_INC;
            cmd.set_status = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            // hold until the output register can take the result
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // after an abort nothing can be inserted, so the store is never written
   a_no_write_after_abort: assert property (@(posedge clock) disable iff (reset)
      st.aborted |-> cmd.wr_mode == WR_NONE)
      else $error("store written after abort");

   a_no_grow_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_mode == CNT_INC |-> !st.full)
      else $error("entry count grows past depth");

   a_scan_not_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_SHDN) |-> !st.empty)
      else $error("scan running on an empty store");

endmodule

>>> rtl/core/kdq_datapath.sv
// Datapath of the keyed deque: entry store, scan index, entry count, abort
// flag, request and result registers. Depends on kdq_pkg; driven by kdq_ctrl.
module kdq_datapath import kdq_pkg::*; #(
   parameter int DEPTH        = DEPTH_DEF,
   parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kdq_cmd_type            cmd,
   output kdq_stat_type           st,
   input  logic [TYPE_W-1:0]      req_type,
   input  logic signed [ID_W-1:0] req_key_id,
   input  logic [HDL_PORT_W-1:0]  req_entry_handle,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [HDL_PORT_W-1:0]  rsp_entry_out,
   output logic [OCC_W-1:0]       rsp_occupancy,
   output logic                   rsp_is_aborted
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = (HANDLE_WIDTH < HDL_PORT_W) ? HANDLE_WIDTH : HDL_PORT_W;
   localparam int EW = SW + ID_W;

   logic [EW-1:0]       mem [DEPTH];

   logic [TYPE_W-1:0]   op_ff;
   logic [ID_W-1:0]     id_ff;
   logic [SW-1:0]       hdl_ff;
   logic [CW-1:0]       count_ff, count_in, count_m1;
   logic                aborted_ff;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [EW-1:0]       rd_data_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [SW-1:0]       res_hdl_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SW-1:0]       rsp_hdl_ff;
   logic [CW-1:0]       rsp_count_ff;
   logic                rsp_abort_ff;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [EW-1:0]       wr_data;
   logic [SW-1:0]       rd_hdl;
   logic [ID_W-1:0]     rd_id;
   logic                hdl_nz;

   assign rd_hdl   = rd_data_ff[EW-1:ID_W];
   assign rd_id    = rd_data_ff[ID_W-1:0];
   assign hdl_nz   = (rd_hdl != '0);
   assign count_m1 = count_ff - CW'(1);

   always_comb begin
      unique case (cmd.idx_mode)
         IDX_ZERO: idx_in = '0;
         IDX_INC:  idx_in = idx_ff + AW'(1);
         IDX_DEC:  idx_in = idx_ff - AW'(1);
         IDX_TOP:  idx_in = count_m1[AW-1:0];
         default:  idx_in = idx_ff;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = {hdl_ff, id_ff};
      unique case (cmd.wr_mode)
         WR_BACK:  wr_addr = count_ff[AW-1:0];
         WR_FRONT: wr_addr = '0;
         WR_UP: begin
            wr_addr = idx_ff + AW'(1);
            wr_data = rd_data_ff;
         end
         WR_DOWN: begin
            wr_addr = idx_ff - AW'(1);
            wr_data = rd_data_ff;
         end
         default:  wr_en = 1'b0;
      endcase
   end

   always_comb begin
      unique case (cmd.cnt_mode)
         CNT_INC: count_in = count_ff + CW'(1);
         CNT_DEC: count_in = count_m1;
         CNT_CLR: count_in = '0;
         default: count_in = count_ff;
      endcase
   end

   // entry store: one write port, one registered read port at the next index
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[idx_in];
      idx_ff     <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff  <= req_type;
         id_ff  <= req_key_id;
         hdl_ff <= req_entry_handle[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         res_status_ff <= ST_NONE;
         res_hdl_ff    <= '0;
      end else begin
         if (cmd.set_status) begin
            res_status_ff <= cmd.status;
         end
         if (cmd.take_hit) begin
            res_hdl_ff <= rd_hdl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         aborted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.set_abort) begin
            aborted_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_hdl_ff    <= res_hdl_ff;
         rsp_count_ff  <= count_ff;
         rsp_abort_ff  <= aborted_ff;
      end
   end

   always_comb begin
      st.op       = op_ff;
      st.aborted  = aborted_ff;
      st.full     = (count_ff == CW'(DEPTH));
      st.empty    = (count_ff == '0);
      st.last     = (CW'(idx_ff) + CW'(1)) >= count_ff;
      st.idx_zero = (idx_ff == '0);
      st.out_free = !rsp_valid_ff || rsp_ready;
      unique case (op_ff)
         OP_POP_FRONT: st.hit = hdl_nz;
         OP_POP_ID:    st.hit = hdl_nz && (rd_id == id_ff);
         OP_REMOVE:    st.hit = hdl_nz && (rd_hdl == hdl_ff);
         OP_FIND:      st.hit = (rd_id == id_ff);
         default:      st.hit = 1'b0;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_entry_out  = HDL_PORT_W'(rsp_hdl_ff);
   assign rsp_occupancy  = OCC_W'(rsp_count_ff);
   assign rsp_is_aborted = rsp_abort_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_abort_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(aborted_ff) && !$past(reset) |-> aborted_ff)
      else $error("abort flag cleared without reset");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> CW'(wr_addr) <= count_ff)
      else $error("store write beyond the held entries");

endmodule

>>> rtl/core/keyed_deque_with_abort.sv
// Keyed deque with abort: an ordered store of handle/id entries with
// insert at either end, pops, keyed removal, lookup, clear and abort.
//
// Requests arrive on req_ch and each gives exactly one result on rsp_ch;
// both are valid/ready channels, a transfer happens when valid and ready
// are both high. One request is worked on at a time; req_ch.ready is high
// while the controller is idle, even if the previous result still waits
// in the output register, so a stalled receiver delays only the finish of
// the following request, never a held result.
// Append, clear, abort, refusals and requests on an empty store finish
// straight after dispatch; push front first moves each held entry one
// place back, the last one first, then writes the front; pop, remove and
// find read one entry a cycle from the front through the store's
// registered read port, then shift the entries behind a removed one
// forward one per cycle. The controller returns to idle between requests.
// Reset (synchronous) empties the store and clears the abort flag; store
// contents need no clearing pass since only held positions are read.
// Depends on kdq_pkg, kdq_if, kdq_ctrl and kdq_datapath.
module keyed_deque_with_abort import kdq_pkg::*; #(
   parameter int DEPTH        = DEPTH_DEF,
   parameter int HANDLE_WIDTH = HANDLE_WIDTH_DEF
) (
   input logic      clock,
   input logic      reset,
   kdq_req_if.sink  req_ch,
   kdq_rsp_if.source rsp_ch
);

   kdq_cmd_type  cmd;
   kdq_stat_type st;

   kdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .st        (st),
      .cmd       (cmd)
   );

   kdq_datapath #(
      .DEPTH        (DEPTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_type         (req_ch.req_type),
      .req_key_id       (req_ch.key_id),
      .req_entry_handle (req_ch.entry_handle),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_status       (rsp_ch.status),
      .rsp_entry_out    (rsp_ch.entry_out),
      .rsp_occupancy    (rsp_ch.occupancy),
      .rsp_is_aborted   (rsp_ch.is_aborted)
   );

endmodule

>>> bench/keyed_deque_with_abort_test.sv
`timescale 1ns / 100ps
// Testbench for keyed_deque_with_abort: directed rows, random request mixes, abort rows.
// Results are checked against fixed row results or a behavioral deque model in this file.
// Depends on kdq_pkg, kdq_if and the keyed_deque_with_abort RTL.
module keyed_deque_with_abort_test;
   import kdq_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 1400;
   localparam int HEAD_ROWS    = 18;
   localparam int ALL_ROWS     = 25;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [HDL_PORT_W-1:0] entry;
      logic [OCC_W-1:0]      occ;
      logic                  aborted;
   } deque_result_type;

   typedef struct {
      logic [TYPE_W-1:0]      op;
      logic signed [ID_W-1:0] id;
      logic [HDL_PORT_W-1:0]  handle;
      bit                     fixed;
      deque_result_type       want;
   } stim_row_type;

   typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} mix_type;

   logic clock;
   logic reset;

   kdq_req_if req_bus ();
   kdq_rsp_if rsp_bus ();

   keyed_deque_with_abort u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // model of the store contents
   logic [HDL_PORT_W-1:0]  held_handle [DEPTH_DEF];
   logic signed [ID_W-1:0] held_id     [DEPTH_DEF];
   int                     held_count;
   logic                   aborted_now;

   deque_result_type awaited_results [$];
   stim_row_type     directed_rows [ALL_ROWS];
   int               fail_count;
   int               cycle_count;
   int               burst_left;
   logic [1:0]       stall_mode;
   logic [6:0]       stall_timer;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("keyed_deque_with_abort_test failed");
         $finish;
      end
   end

   function automatic deque_result_type apply_request(input stim_row_type row);
      deque_result_type r;
      int               i;
      int               found;
      r = {ST_NONE, {HDL_PORT_W{1'b0}}, {OCC_W{1'b0}}, 1'b0};
      found = -1;
      case (row.op)
         OP_APPEND, OP_PUSH: begin
            if (aborted_now) begin
               r.status = ST_ABORTED;
            end else if (held_count >= DEPTH_DEF) begin
               r.status = ST_FULL;
            end else begin
               if (row.op == OP_PUSH) begin
                  for (i = held_count; i > 0; i--) begin
                     held_handle[i] = held_handle[i-1];
                     held_id[i]     = held_id[i-1];
                  end
                  held_handle[0] = row.handle;
                  held_id[0]     = row.id;
               end else begin
                  held_handle[held_count] = row.handle;
                  held_id[held_count]     = row.id;
               end
               held_count++;
               r.status = ST_OK;
            end
         end
         OP_POP_FRONT, OP_POP_ID, OP_REMOVE: begin
            // entries with a null handle are passed over and stay put
            for (i = 0; i < held_count && found < 0; i++) begin
               if (held_handle[i] != '0 &&
                   (row.op == OP_POP_FRONT ||
                    (row.op == OP_POP_ID && held_id[i] == row.id) ||
                    (row.op == OP_REMOVE && held_handle[i] == row.handle)))
                  found = i;
            end
            if (found >= 0) begin
               r.status = ST_OK;
               r.entry  = held_handle[found];
               for (i = found; i + 1 < held_count; i++) begin
                  held_handle[i] = held_handle[i+1];
                  held_id[i]     = held_id[i+1];
               end
               held_count--;
            end
         end
         OP_FIND: begin
            for (i = 0; i < held_count && found < 0; i++)
               if (held_id[i] == row.id) found = i;
            if (found >= 0) begin
               r.status = ST_OK;
               r.entry  = held_handle[found];
            end
         end
         OP_CLEAR: begin
            held_count = 0;
            r.status   = ST_OK;
         end
         default: begin
            aborted_now = 1'b1;
            held_count  = 0;
            r.status    = ST_OK;
         end
      endcase
      r.occ     = OCC_W'(held_count);
      r.aborted = aborted_now;
      return r;
   endfunction

   // Outside the noise mix, ids and handles lean on what the store holds so that searches hit.
   function automatic stim_row_type random_request(input mix_type mix);
      stim_row_type row;
      int unsigned  roll;
      roll       = $urandom_range(0, 99);
      row.fixed  = 1'b0;
      row.want   = '0;
      row.id     = $urandom;
      row.handle = ($urandom_range(0, 9) == 0) ? '0 : HDL_PORT_W'($urandom);
      case (mix)
         PH_FILL:  row.op = (roll < 45) ? OP_APPEND : (roll < 85) ? OP_PUSH :
                            TYPE_W'($urandom_range(OP_POP_FRONT, OP_FIND));
         PH_DRAIN: row.op = (roll < 25) ? OP_POP_FRONT : (roll < 50) ? OP_POP_ID :
                            (roll < 70) ? OP_REMOVE : (roll < 85) ? OP_FIND :
                            (roll < 95) ? TYPE_W'($urandom_range(OP_APPEND, OP_PUSH)) :
                            OP_CLEAR;
         default: begin
            row.op = TYPE_W'($urandom_range(OP_APPEND, OP_CLEAR));
            if (row.op == OP_CLEAR && roll >= 20) row.op = OP_FIND;
         end
      endcase
      if (mix == PH_NOISE) return row;
      if (held_count > 0 && $urandom_range(0, 9) < 6) begin
         row.id = held_id[$urandom_range(0, held_count - 1)];
      end else begin
         case ($urandom_range(0, 5))
            0: row.id = -32'sd1;
            1: row.id = 32'sd0;
            2: row.id = 32'sd1;
            3: row.id = 32'sh7FFF_FFFF;
            4: row.id = 32'sh8000_0000;
            default: row.id = $urandom;
         endcase
      end
      if (row.op == OP_REMOVE && held_count > 0 && roll < 70)
         row.handle = held_handle[$urandom_range(0, held_count - 1)];
      return row;
   endfunction

   // Drive one request and hold it until the transfer; log what it should return.
   task automatic send_req(input stim_row_type row);
      int               gap;
      deque_result_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= row.op;
      req_bus.key_id       <= row.id;
      req_bus.entry_handle <= row.handle;
      do @(posedge clock); while (!req_bus.ready);
      predicted = apply_request(row);
      awaited_results.push_back(row.fixed ? row.want : predicted);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_mode    <= 2'd0;
         stall_timer   <= '0;
      end else begin
         stall_timer <= stall_timer + 1'b1;
         if (stall_timer == '0) stall_mode <= 2'($urandom_range(0, 3));
         case (stall_mode)
            2'd0:    rsp_bus.ready <= 1'b1;
            2'd1:    rsp_bus.ready <= 1'($urandom_range(0, 1));
            2'd2:    rsp_bus.ready <= ($urandom_range(0, 4) == 0);
            default: rsp_bus.ready <= (stall_timer[1:0] != 2'b11);
         endcase
      end
   end

   always @(posedge clock) begin : check_results
      deque_result_type got;
      deque_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.status, rsp_bus.entry_out, rsp_bus.occupancy, rsp_bus.is_aborted};
         if (awaited_results.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected result: status %0d entry %h occ %0d aborted %0b",
                        got.status, got.entry, got.occ, got.aborted);
         end else begin
            want = awaited_results.pop_front();
            if (got.status !== want.status || got.entry !== want.entry ||
                got.occ !== want.occ || got.aborted !== want.aborted) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: exp %0d/%h/%0d/%0b got %0d/%h/%0d/%0b",
                           want.status, want.entry, want.occ, want.aborted,
                           got.status, got.entry, got.occ, got.aborted);
            end
         end
      end
   end

   initial begin : stimulus
      stim_row_type row;
      mix_type      mix;
      int           mix_left;
      int           n;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.req_type     = OP_APPEND;
      req_bus.key_id       = '0;
      req_bus.entry_handle = '0;
      rsp_bus.ready        = 1'b0;
      fail_count           = 0;
      cycle_count          = 0;
      burst_left           = 0;
      held_count           = 0;
      aborted_now          = 1'b0;

      // empty store, extremes, null handles being skipped, clear
      directed_rows[0]  = '{OP_POP_FRONT, 32'sd0, 32'd0, 1'b1, {ST_NONE, 32'd0, 5'd0, 1'b0}};
      directed_rows[1]  = '{OP_FIND, 32'sd0, 32'd0, 1'b1, {ST_NONE, 32'd0, 5'd0, 1'b0}};
      directed_rows[2]  = '{OP_REMOVE, 32'sd0, 32'd0, 1'b1, {ST_NONE, 32'd0, 5'd0, 1'b0}};
      directed_rows[3]  = '{OP_APPEND, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b1,
                            {ST_OK, 32'd0, 5'd1, 1'b0}};
      directed_rows[4]  = '{OP_PUSH, 32'sh7FFF_FFFF, 32'd0, 1'b1, {ST_OK, 32'd0, 5'd2, 1'b0}};
      directed_rows[5]  = '{OP_APPEND, 32'sh7FFF_FFFF, 32'd1, 1'b1, {ST_OK, 32'd0, 5'd3, 1'b0}};
      directed_rows[6]  = '{OP_FIND, 32'sh7FFF_FFFF, 32'd0, 1'b1, {ST_OK, 32'd0, 5'd3, 1'b0}};
      directed_rows[7]  = '{OP_POP_ID, 32'sh7FFF_FFFF, 32'd0, 1'b0, '0};
      directed_rows[8]  = '{OP_POP_FRONT, 32'sd0, 32'd0, 1'b0, '0};
      directed_rows[9]  = '{OP_REMOVE, 32'sd0, 32'd0, 1'b1, {ST_NONE, 32'd0, 5'd1, 1'b0}};
      directed_rows[10] = '{OP_POP_FRONT, 32'sd0, 32'd0, 1'b0, '0};
      directed_rows[11] = '{OP_APPEND, -32'sd1, 32'h5555_5555, 1'b0, '0};
      directed_rows[12] = '{OP_APPEND, 32'sd0, 32'hAAAA_AAAA, 1'b0, '0};
      directed_rows[13] = '{OP_REMOVE, 32'sd0, 32'hAAAA_AAAA, 1'b0, '0};
      directed_rows[14] = '{OP_POP_ID, -32'sd1, 32'd0, 1'b0, '0};
      directed_rows[15] = '{OP_FIND, 32'sd12345, 32'd0, 1'b0, '0};
      directed_rows[16] = '{OP_CLEAR, 32'sd0, 32'd0, 1'b1, {ST_OK, 32'd0, 5'd0, 1'b0}};
      directed_rows[17] = '{OP_APPEND, 32'sh5555_5555, 32'hAAAA_AAAA, 1'b0, '0};
      // an append, then abort and everything after it; run last since only reset lifts it
      directed_rows[18] = '{OP_APPEND, 32'sd3, 32'd3, 1'b0, '0};
      directed_rows[19] = '{OP_ABORT, 32'sd0, 32'd0, 1'b1, {ST_OK, 32'd0, 5'd0, 1'b1}};
      directed_rows[20] = '{OP_APPEND, 32'sd4, 32'd4, 1'b1, {ST_ABORTED, 32'd0, 5'd0, 1'b1}};
      directed_rows[21] = '{OP_PUSH, 32'sd5, 32'd5, 1'b1, {ST_ABORTED, 32'd0, 5'd0, 1'b1}};
      directed_rows[22] = '{OP_POP_FRONT, 32'sd0, 32'd0, 1'b1, {ST_NONE, 32'd0, 5'd0, 1'b1}};
      directed_rows[23] = '{OP_CLEAR, 32'sd0, 32'd0, 1'b1, {ST_OK, 32'd0, 5'd0, 1'b1}};
      directed_rows[24] = '{OP_ABORT, 32'sd0, 32'd0, 1'b1, {ST_OK, 32'd0, 5'd0, 1'b1}};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < HEAD_ROWS; n++) send_req(directed_rows[n]);

      // open with a fill so the full status shows up early
      mix      = PH_FILL;
      mix_left = 24;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (mix_left == 0) begin
            mix      = mix_type'($urandom_range(0, 3));
            mix_left = $urandom_range(6, 40);
         end
         mix_left--;
         row = random_request(mix);
         send_req(row);
      end

      for (n = HEAD_ROWS; n < ALL_ROWS; n++) send_req(directed_rows[n]);
      req_bus.valid <= 1'b0;

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("keyed_deque_with_abort_test passed");
      end else begin
         $display("keyed_deque_with_abort_test failed");
      end
      $finish;
   end

endmodule
